// ===== sv/peu_pkg.sv =====
package peu_pkg;

    localparam int NUM_PARTICLES = 64;
    localparam int SLOT_W = 6;

    localparam logic [2:0] REG_EMIT_POS   = 3'd0;
    localparam logic [2:0] REG_BASE_DIR   = 3'd1;
    localparam logic [2:0] REG_START_COL  = 3'd2;
    localparam logic [2:0] REG_END_COL    = 3'd3;
    localparam logic [2:0] REG_LIFE       = 3'd4;
    localparam logic [2:0] REG_SPEED      = 3'd5;
    localparam logic [2:0] REG_SPREAD_X   = 3'd6;
    localparam logic [2:0] REG_SPREAD_Y   = 3'd7;

    localparam logic CMD_INIT = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] now_ms;
        logic [15:0] dt_seconds;
        logic [14:0] random_x;
        logic [14:0] random_y;
    } t_in_item;

    typedef struct packed {
        logic [5:0]         slot;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0]        color_out;
        logic               last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FADE,
        ST_FADE_WAIT,
        ST_JIT,
        ST_JIT_WAIT,
        ST_RD,
        ST_MUL1,
        ST_MUL2,
        ST_WB,
        ST_OUT_RD,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic               init_clear;
        logic               div_start;
        logic [2:0]         div_sel;
        logic               fade_store;
        logic               jit_store;
        logic               arm_check;
        logic               rd;
        logic               mul1;
        logic               mul2;
        logic               wb;
        logic               out_rd;
        logic [SLOT_W-1:0]  slot;
        logic [1:0]         chan;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic div_busy;
        logic alive_slot;
    } t_sts;

endpackage

// ===== sv/peu_div.sv =====
// restoring divider, one quotient bit a cycle, magnitudes
module peu_div
    import peu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_busy,
    output logic [31:0] o_quot,
    output logic [15:0] o_rem
);
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_q, n_q;
    logic [16:0] r_r, n_r;
    logic [15:0] r_d;
    logic [16:0] sh;

    always_comb begin
        n_cnt = r_cnt;
        n_q = r_q;
        n_r = r_r;
        sh = {r_r[15:0], r_q[31]};
        if (i_start) begin
            n_cnt = 6'd32;
            n_q = i_num;
            n_r = '0;
        end else if (r_cnt != 6'd0) begin
            n_cnt = r_cnt - 6'd1;
            if (sh >= {1'b0, r_d}) begin
                n_r = sh - {1'b0, r_d};
                n_q = {r_q[30:0], 1'b1};
            end else begin
                n_r = sh;
                n_q = {r_q[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        if (i_start) begin
            r_d <= i_den;
        end
    end

    assign o_busy = (r_cnt != 6'd0);
    assign o_quot = r_q;
    assign o_rem  = r_r[15:0];
endmodule

// ===== sv/peu_ctrl.sv =====
module peu_ctrl
    import peu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_cmd,
    input  logic     i_out_busy,
    input  t_sts     i_sts,
    output t_ctl     o_ctl
);
    t_state r_state, n_state;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [1:0]        r_chan, n_chan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_slot <= '0;
            r_chan <= '0;
        end else begin
            r_state <= n_state;
            r_slot <= n_slot;
            r_chan <= n_chan;
        end
    end

    always_comb begin
        n_state = r_state;
        n_slot = r_slot;
        n_chan = r_chan;
        o_ctl = '0;
        o_ctl.slot = r_slot;
        o_ctl.chan = r_chan;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_chan = '0;
                    n_slot = '0;
                    if (i_cmd == CMD_INIT) begin
                        o_ctl.init_clear = 1'b1;
                        n_state = ST_FADE;
                    end else begin
                        o_ctl.arm_check = 1'b1;
                        n_state = ST_JIT;
                    end
                end
            end
            // four fade rate divisions
            ST_FADE: begin
                o_ctl.div_start = 1'b1;
                o_ctl.div_sel = {1'b0, r_chan};
                n_state = ST_FADE_WAIT;
            end
            ST_FADE_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_ctl.fade_store = 1'b1;
                    n_chan = r_chan + 2'd1;
                    n_state = (r_chan == 2'd3) ? ST_IDLE : ST_FADE;
                end
            end
            // two jitter modulos
            ST_JIT: begin
                o_ctl.div_start = 1'b1;
                o_ctl.div_sel = {2'b10, r_chan[0]};
                n_state = ST_JIT_WAIT;
            end
            ST_JIT_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_ctl.jit_store = 1'b1;
                    n_chan = r_chan + 2'd1;
                    n_state = r_chan[0] ? ST_RD : ST_JIT;
                end
            end
            // slot update sweep
            ST_RD: begin
                o_ctl.rd = 1'b1;
                n_state = ST_MUL1;
            end
            ST_MUL1: begin
                o_ctl.mul1 = 1'b1;
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                o_ctl.mul2 = 1'b1;
                n_state = ST_WB;
            end
            ST_WB: begin
                o_ctl.wb = 1'b1;
                n_slot = r_slot + 1'b1;
                n_state = (r_slot == SLOT_W'(NUM_PARTICLES - 1)) ? ST_OUT_RD : ST_RD;
            end
            // report sweep
            ST_OUT_RD: begin
                if (!i_sts.alive_slot) begin
                    n_slot = r_slot + 1'b1;
                    if (r_slot == SLOT_W'(NUM_PARTICLES - 1)) n_state = ST_IDLE;
                end else if (!i_out_busy) begin
                    o_ctl.out_rd = 1'b1;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                n_slot = r_slot + 1'b1;
                n_state = (r_slot == SLOT_W'(NUM_PARTICLES - 1)) ? ST_IDLE : ST_OUT_RD;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ===== sv/peu_dp.sv =====
module peu_dp
    import peu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_xfer,
    input  t_in_item    i_in,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    input  t_ctl        i_ctl,
    output t_sts        o_sts,
    output logic        o_out_load,
    output t_out_item   o_out
);
    // configuration
    logic [47:0] r_emit_pos, r_base_dir;
    logic [31:0] r_start_col, r_end_col;
    logic [15:0] r_life, r_speed, r_spread_x, r_spread_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_pos <= '0;
            r_base_dir <= '0;
            r_start_col <= '1;
            r_end_col <= '0;
            r_life <= 16'd1000;
            r_speed <= '0;
            r_spread_x <= 16'd1;
            r_spread_y <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_EMIT_POS:  r_emit_pos <= i_cfg_data;
                REG_BASE_DIR:  r_base_dir <= i_cfg_data;
                REG_START_COL: r_start_col <= i_cfg_data[31:0];
                REG_END_COL:   r_end_col <= i_cfg_data[31:0];
                REG_LIFE:      r_life <= i_cfg_data[15:0];
                REG_SPEED:     r_speed <= i_cfg_data[15:0];
                REG_SPREAD_X:  r_spread_x <= i_cfg_data[15:0];
                REG_SPREAD_Y:  r_spread_y <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic [15:0] life_eff;
    assign life_eff = (r_life == 16'd0) ? 16'd1 : r_life;

    // latched item
    logic [31:0] r_now;
    logic [15:0] r_dt;
    logic [14:0] r_rx, r_ry;
    always_ff @(posedge i_clk) begin
        if (i_in_xfer) begin
            r_now <= i_in.now_ms;
            r_dt <= i_in.dt_seconds;
            r_rx <= i_in.random_x;
            r_ry <= i_in.random_y;
        end
    end

    // shared divider
    logic        div_busy;
    logic [31:0] div_q;
    logic [15:0] div_r;
    logic [31:0] div_num;
    logic [15:0] div_den;
    logic signed [9:0] fade_diff;
    logic [7:0]  ec, sc;
    logic [15:0] sp_sel;

    always_comb begin
        ec = r_end_col[8*i_ctl.chan +: 8];
        sc = r_start_col[8*i_ctl.chan +: 8];
        fade_diff = $signed({2'b0, ec}) - $signed({2'b0, sc});
        sp_sel = i_ctl.chan[0] ? r_spread_y : r_spread_x;
        if (sp_sel == 16'd0) sp_sel = 16'd1;
        if (i_ctl.div_sel[2]) begin
            div_num = {17'd0, i_ctl.chan[0] ? r_ry : r_rx};
            div_den = sp_sel;
        end else begin
            // |diff| * 256000 fits 26 bits
            div_num = 32'(fade_diff[9] ? -fade_diff : fade_diff) * 32'd256000;
            div_den = life_eff;
        end
    end

    peu_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_ctl.div_start),
        .i_num(div_num), .i_den(div_den), .o_busy(div_busy),
        .o_quot(div_q), .o_rem(div_r)
    );

    // fade rates
    logic signed [23:0] r_fade [4];
    logic               r_neg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) r_fade[k] <= '0;
        end else if (i_ctl.fade_store) begin
            if (div_q > 32'd8388607)
                r_fade[i_ctl.chan] <= r_neg ? 24'sh800000 : 24'sh7FFFFF;
            else
                r_fade[i_ctl.chan] <= r_neg ? -$signed(div_q[23:0]) : $signed(div_q[23:0]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_ctl.div_start) r_neg <= fade_diff[9];
    end

    // jitter: (r mod s - s/2) * 4096 / 1000 toward zero
    logic signed [16:0] jd;
    logic signed [30:0] jm;
    logic [30:0]        jmag;
    logic [20:0]        jq;
    logic signed [18:0] jdir;
    logic signed [19:0] jsum;
    logic signed [15:0] r_dir_x, r_dir_y;
    always_comb begin
        jd = $signed({1'b0, div_r}) - $signed({1'b0, 1'b0, sp_sel[15:1]});
        jm = 31'(jd) * 31'sd4096;
        jmag = jm[30] ? 31'(-jm) : 31'(jm);
        // exact floor divide by 1000 over this range (< 2^29)
        jq = 21'((64'(jmag) * 64'd2199023256) >> 41);
        jdir = jm[30] ? -$signed({1'b0, jq[17:0]}) : $signed({1'b0, jq[17:0]});
        jsum = 20'(i_ctl.chan[0] ? $signed(r_base_dir[31:16]) : $signed(r_base_dir[15:0]))
             + 20'(jdir);
    end
    always_ff @(posedge i_clk) begin
        if (i_ctl.jit_store) begin
            if (i_ctl.chan[0])
                r_dir_y <= (jsum > 20'sd32767) ? 16'sh7FFF :
                           (jsum < -20'sd32768) ? 16'sh8000 : jsum[15:0];
            else
                r_dir_x <= (jsum > 20'sd32767) ? 16'sh7FFF :
                           (jsum < -20'sd32768) ? 16'sh8000 : jsum[15:0];
        end
    end

    // spawn arming
    logic        r_pending;
    logic [31:0] r_last_spawn;
    logic [31:0] since;
    assign since = i_in.now_ms - r_last_spawn;

    // per-slot state
    logic [NUM_PARTICLES-1:0] r_alive;
    logic [31:0] m_birth [NUM_PARTICLES];
    logic [31:0] m_px [NUM_PARTICLES];
    logic [31:0] m_py [NUM_PARTICLES];
    logic [31:0] m_pz [NUM_PARTICLES];
    logic [47:0] m_dir [NUM_PARTICLES];
    logic [63:0] m_col [NUM_PARTICLES];
    logic [15:0] m_spd [NUM_PARTICLES];

    logic [31:0] r_birth, r_px, r_py, r_pz;
    logic [47:0] r_dir;
    logic [63:0] r_col;
    logic [15:0] r_spd;
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd || i_ctl.out_rd) begin
            r_birth <= m_birth[i_ctl.slot];
            r_px <= m_px[i_ctl.slot];
            r_py <= m_py[i_ctl.slot];
            r_pz <= m_pz[i_ctl.slot];
            r_dir <= m_dir[i_ctl.slot];
            r_col <= m_col[i_ctl.slot];
            r_spd <= m_spd[i_ctl.slot];
        end
    end

    // stage 1: dt*speed, fade steps
    logic [31:0] r_dts;
    logic signed [39:0] r_fstep [4];
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul1) begin
            r_dts <= 32'(r_dt) * 32'(r_spd);
            for (int k = 0; k < 4; k++)
                r_fstep[k] <= 40'(r_fade[k]) * $signed({24'd0, r_dt});
        end
    end

    // stage 2: times direction (33x16 signed)
    logic signed [48:0] r_d [3];
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul2) begin
            for (int k = 0; k < 3; k++)
                r_d[k] <= $signed({1'b0, r_dts}) * $signed(r_dir[16*k +: 16]);
        end
    end

    function automatic logic [31:0] sat_add(input logic [31:0] p, input logic signed [48:0] d);
        logic signed [36:0] s;
        logic signed [36:0] step;
        begin
            step = 37'(d >>> 12);
            s = 37'($signed(p)) + step;
            if (s > 37'sd2147483647) sat_add = 32'h7FFFFFFF;
            else if (s < -37'sd2147483648) sat_add = 32'h80000000;
            else sat_add = s[31:0];
        end
    endfunction

    logic        expired;
    logic [63:0] new_col;
    logic signed [24:0] fs;
    logic signed [25:0] cs;
    logic [63:0] spawn_col;
    logic        do_spawn;
    assign expired = (r_now - r_birth) > {16'd0, life_eff};
    assign do_spawn = !r_alive[i_ctl.slot] && r_pending && (r_speed != 16'd0);
    always_comb begin
        new_col = '0;
        spawn_col = '0;
        for (int k = 0; k < 4; k++) begin
            fs = 25'(r_fstep[k] >>> 16);
            cs = 26'($signed({1'b0, r_col[16*k +: 16]})) + 26'(fs);
            if (cs < 0) new_col[16*k +: 16] = 16'd0;
            else if (cs > 26'sd65535) new_col[16*k +: 16] = 16'hFFFF;
            else new_col[16*k +: 16] = cs[15:0];
            spawn_col[16*k +: 16] = {r_start_col[8*k +: 8], 8'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wb) begin
            if (r_alive[i_ctl.slot] && !expired) begin
                m_px[i_ctl.slot] <= sat_add(r_px, r_d[0]);
                m_py[i_ctl.slot] <= sat_add(r_py, r_d[1]);
                m_pz[i_ctl.slot] <= sat_add(r_pz, r_d[2]);
                m_col[i_ctl.slot] <= new_col;
            end else if (do_spawn) begin
                m_birth[i_ctl.slot] <= r_now;
                m_px[i_ctl.slot] <= {r_emit_pos[15:0], 16'd0};
                m_py[i_ctl.slot] <= {r_emit_pos[31:16], 16'd0};
                m_pz[i_ctl.slot] <= {r_emit_pos[47:32], 16'd0};
                m_dir[i_ctl.slot] <= {r_base_dir[47:32], r_dir_y, r_dir_x};
                m_col[i_ctl.slot] <= spawn_col;
                m_spd[i_ctl.slot] <= r_speed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= '0;
            r_pending <= 1'b0;
            r_last_spawn <= '0;
        end else begin
            if (i_ctl.init_clear) r_alive <= '0;
            if (i_ctl.arm_check && ({32'd0, since} * 64'(NUM_PARTICLES) > 64'(life_eff)))
                r_pending <= 1'b1;
            if (i_ctl.wb) begin
                if (r_alive[i_ctl.slot]) begin
                    if (expired) r_alive[i_ctl.slot] <= 1'b0;
                end else if (do_spawn) begin
                    r_alive[i_ctl.slot] <= 1'b1;
                    r_pending <= 1'b0;
                    r_last_spawn <= r_now;
                end
            end
        end
    end

    // report: last when no live slot above
    logic [NUM_PARTICLES-1:0] above;
    assign above = r_alive & ~((NUM_PARTICLES'(2) << i_ctl.slot) - NUM_PARTICLES'(1));

    logic r_out_pend;
    logic r_last;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_pend <= 1'b0;
        else r_out_pend <= i_ctl.out_rd;
        if (i_ctl.out_rd) r_last <= (above == '0);
    end

    assign o_out_load = r_out_pend;
    always_comb begin
        o_out.slot = i_ctl.slot;
        o_out.pos_x = r_px;
        o_out.pos_y = r_py;
        o_out.pos_z = r_pz;
        o_out.color_out = {r_col[63:56], r_col[47:40], r_col[31:24], r_col[15:8]};
        o_out.last = r_last;
    end

    assign o_sts.div_busy = div_busy;
    assign o_sts.alive_slot = r_alive[i_ctl.slot];
endmodule

// ===== sv/particle_emitter_update.sv =====
// channel | direction | handshake         | payload
// in      | input     | i_in_valid/ready  | t_in_item
// out     | output    | o_out_valid/ready | t_out_item
// cfg     | input     | i_cfg_we          | i_cfg_idx, i_cfg_data
// init runs the four fade rate divisions on the shared 32-step divider.
// tick: two jitter divisions on the divider, then read, two multiply steps and write-back
// for each of the 64 slots, then the report sweep, which skips dead slots and reads out each
// live slot, waiting while the output register still holds the previous result.
// reset clears the live flags, fade rates and spawn timing; slot memory needs no clear.
// an output stall holds the report sweep; the output register holds one result.
module particle_emitter_update
    import peu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data
);
    t_ctl ctl;
    t_sts sts;
    logic out_load;
    t_out_item out_item;
    logic r_out_valid;
    t_out_item r_out;

    peu_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .i_cmd(i_in_data.cmd),
        .i_out_busy(r_out_valid), .i_sts(sts), .o_ctl(ctl)
    );

    peu_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_xfer(i_in_valid && o_in_ready),
        .i_in(i_in_data), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_ctl(ctl), .o_sts(sts),
        .o_out_load(out_load), .o_out(out_item)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) r_out <= out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> !r_out_valid || i_out_ready)
        else $error("output overwritten");
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !o_in_ready || !ctl.out_rd)
        else $error("accept while reporting");
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.div_start |-> !sts.div_busy)
        else $error("divider restarted while busy");
`endif
endmodule

// ===== tb/tb.sv =====
module tb;
    import peu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint POS_MIN = -POS_MAX - 1;
    localparam int     SETTLE_CYCLES = 600;
    localparam int     LONG_HOLD = 3000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [47:0] i_cfg_data;

    particle_emitter_update uut (.*);

    // emitter settings as the block should hold them
    logic [47:0] emit_pos, base_dir;
    logic [31:0] start_col, end_col;
    logic [15:0] life_ms, speed, spread_x, spread_y;

    // particle pool as the block should hold it
    bit                 slot_alive [NUM_PARTICLES];
    logic [31:0]        slot_birth [NUM_PARTICLES];
    int                 slot_px [NUM_PARTICLES];
    int                 slot_py [NUM_PARTICLES];
    int                 slot_pz [NUM_PARTICLES];
    logic signed [15:0] slot_dx [NUM_PARTICLES];
    logic signed [15:0] slot_dy [NUM_PARTICLES];
    logic signed [15:0] slot_dz [NUM_PARTICLES];
    logic [15:0]        slot_col [NUM_PARTICLES][4];
    logic [15:0]        slot_speed [NUM_PARTICLES];
    int                 fade_rate [4];
    bit                 spawn_armed;
    logic [31:0]        last_spawn;

    t_out_item expected_particles[$];
    int        n_errors;
    int        n_items;
    int        n_reports;
    int        n_spawns;
    bit        quiet;
    bit        hold_req;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint jitter(input logic [14:0] rnd, input logic [15:0] spread);
        longint s;
        longint d;
        s = (spread == 0) ? 1 : longint'(spread);
        d = longint'(rnd) % s - s / 2;
        return d * 4096 / 1000;
    endfunction

    function automatic int move_axis(input int p, input longint dt, input longint sp,
                                     input logic signed [15:0] dir);
        return int'(clamp(longint'(p) + ((dt * sp * longint'(dir)) >>> 12),
                          POS_MIN, POS_MAX));
    endfunction

    // compute what one accepted command produces
    task automatic predict_emitter(input t_in_item it);
        longint      life;
        longint      dt;
        longint      ch;
        logic [31:0] el;
        t_out_item   r;
        int          last_idx;
        life = (life_ms == 0) ? 1 : longint'(life_ms);
        dt = longint'(it.dt_seconds);
        if (it.cmd == CMD_INIT) begin
            for (int i = 0; i < NUM_PARTICLES; i++) slot_alive[i] = 0;
            for (int c = 0; c < 4; c++)
                fade_rate[c] = int'(clamp((longint'(end_col[8*c +: 8]) -
                                           longint'(start_col[8*c +: 8])) * 256000 / life,
                                          -8388608, 8388607));
            return;
        end
        el = it.now_ms - last_spawn;
        if (longint'(el) * NUM_PARTICLES > life) spawn_armed = 1;
        for (int i = 0; i < NUM_PARTICLES; i++) begin
            if (slot_alive[i]) begin
                el = it.now_ms - slot_birth[i];
                if (longint'(el) > life) begin
                    slot_alive[i] = 0;
                end else begin
                    slot_px[i] = move_axis(slot_px[i], dt, slot_speed[i], slot_dx[i]);
                    slot_py[i] = move_axis(slot_py[i], dt, slot_speed[i], slot_dy[i]);
                    slot_pz[i] = move_axis(slot_pz[i], dt, slot_speed[i], slot_dz[i]);
                    for (int c = 0; c < 4; c++) begin
                        ch = longint'(slot_col[i][c]) +
                             ((longint'(fade_rate[c]) * dt) >>> 16);
                        slot_col[i][c] = 16'(clamp(ch, 0, 65535));
                    end
                end
            end else if (spawn_armed && speed != 0) begin
                // revive at the emitter with jittered x and y
                slot_alive[i] = 1;
                slot_birth[i] = it.now_ms;
                slot_px[i] = int'(longint'($signed(emit_pos[15:0])) * 65536);
                slot_py[i] = int'(longint'($signed(emit_pos[31:16])) * 65536);
                slot_pz[i] = int'(longint'($signed(emit_pos[47:32])) * 65536);
                slot_dx[i] = 16'(clamp(longint'($signed(base_dir[15:0])) +
                                       jitter(it.random_x, spread_x), -32768, 32767));
                slot_dy[i] = 16'(clamp(longint'($signed(base_dir[31:16])) +
                                       jitter(it.random_y, spread_y), -32768, 32767));
                slot_dz[i] = $signed(base_dir[47:32]);
                for (int c = 0; c < 4; c++) slot_col[i][c] = {start_col[8*c +: 8], 8'h00};
                slot_speed[i] = speed;
                spawn_armed = 0;
                last_spawn = it.now_ms;
                n_spawns++;
            end
        end
        last_idx = -1;
        for (int i = 0; i < NUM_PARTICLES; i++) begin
            if (slot_alive[i]) begin
                r.slot = i[5:0];
                r.pos_x = slot_px[i];
                r.pos_y = slot_py[i];
                r.pos_z = slot_pz[i];
                for (int c = 0; c < 4; c++) r.color_out[8*c +: 8] = slot_col[i][c][15:8];
                r.last = 1'b0;
                expected_particles.push_back(r);
                last_idx = expected_particles.size() - 1;
            end
        end
        if (last_idx >= 0) expected_particles[last_idx].last = 1'b1;
    endtask

    // register write, only while the block is idle
    task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_EMIT_POS:  emit_pos = data;
            REG_BASE_DIR:  base_dir = data;
            REG_START_COL: start_col = data[31:0];
            REG_END_COL:   end_col = data[31:0];
            REG_LIFE:      life_ms = data[15:0];
            REG_SPEED:     speed = data[15:0];
            REG_SPREAD_X:  spread_x = data[15:0];
            REG_SPREAD_Y:  spread_y = data[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic [47:0] pos, input logic [47:0] dir,
                             input logic [31:0] scol, input logic [31:0] ecol,
                             input logic [15:0] life, input logic [15:0] spd,
                             input logic [15:0] sx, input logic [15:0] sy);
        write_reg(REG_EMIT_POS, pos);
        write_reg(REG_BASE_DIR, dir);
        write_reg(REG_START_COL, {16'h0, scol});
        write_reg(REG_END_COL, {16'h0, ecol});
        write_reg(REG_LIFE, {32'h0, life});
        write_reg(REG_SPEED, {32'h0, spd});
        write_reg(REG_SPREAD_X, {32'h0, sx});
        write_reg(REG_SPREAD_Y, {32'h0, sy});
    endtask

    // offer one command and hold it until the transfer
    task automatic send_cmd(input logic cmd, input logic [31:0] now, input logic [15:0] dt,
                            input logic [14:0] rx, input logic [14:0] ry);
        t_in_item it;
        it.cmd = cmd;
        it.now_ms = now;
        it.dt_seconds = dt;
        it.random_x = rx;
        it.random_y = ry;
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_emitter(it);
        n_items++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    // wait for every report, then let a silent command finish
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_particles.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly steady frames, some inits and wild timestamps
    task automatic run_frames(input int count, input logic [31:0] t0, input int step_max);
        logic [31:0] now;
        int          pick;
        now = t0;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 29);
            if (pick == 0) begin
                send_cmd(CMD_INIT, $urandom, 16'($urandom), 15'($urandom), 15'($urandom));
            end else if (pick == 1) begin
                now = $urandom;
                send_cmd(CMD_TICK, now, 16'($urandom), 15'($urandom), 15'($urandom));
            end else begin
                now = now + $urandom_range(0, step_max);
                send_cmd(CMD_TICK, now, 16'($urandom), 15'($urandom), 15'($urandom));
            end
        end
    endtask

    // receiver side stalls
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    // compare each report transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_particles.size() == 0) begin
                $error("unexpected report for slot %0d", o_out_data.slot);
                n_errors++;
            end else begin
                want = expected_particles.pop_front();
                n_reports++;
                if (o_out_data.slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, o_out_data.slot);
                    n_errors++;
                end
                if (o_out_data.pos_x !== want.pos_x) begin
                    $error("pos_x: expected %0d, got %0d", want.pos_x, o_out_data.pos_x);
                    n_errors++;
                end
                if (o_out_data.pos_y !== want.pos_y) begin
                    $error("pos_y: expected %0d, got %0d", want.pos_y, o_out_data.pos_y);
                    n_errors++;
                end
                if (o_out_data.pos_z !== want.pos_z) begin
                    $error("pos_z: expected %0d, got %0d", want.pos_z, o_out_data.pos_z);
                    n_errors++;
                end
                if (o_out_data.color_out !== want.color_out) begin
                    $error("color_out: expected %h, got %h", want.color_out,
                           o_out_data.color_out);
                    n_errors++;
                end
                if (o_out_data.last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, o_out_data.last);
                    n_errors++;
                end
            end
        end
    end

    // defaults: speed zero never spawns, ticks stay silent
    task automatic test_reset_state();
        send_cmd(CMD_TICK, 32'd5000, 16'hFFFF, 15'h7FFF, 15'h7FFF);
        send_cmd(CMD_INIT, 32'd0, 16'd0, 15'd0, 15'd0);
        send_cmd(CMD_TICK, 32'd9000, 16'd100, 15'd0, 15'd0);
        settle();
    endtask

    // spawning, motion and fade with field extremes
    task automatic test_spawn_motion();
        write_all(48'h0003_FFF9_0010, 48'h0800_F800_1000, 32'h10FF_8020, 32'hFF00_20E0,
                  16'd1000, 16'd7, 16'd100, 16'd37);
        send_cmd(CMD_INIT, 32'd0, 16'd0, 15'd0, 15'd0);
        send_cmd(CMD_TICK, 32'd100, 16'd0, 15'd0, 15'd0);
        send_cmd(CMD_TICK, 32'd200, 16'hFFFF, 15'h7FFF, 15'h7FFF);
        send_cmd(CMD_TICK, 32'd300, 16'h8000, 15'h1234, 15'h4321);
        send_cmd(CMD_TICK, 32'd310, 16'h0001, 15'd50, 15'd18);
        // init clears the pool but keeps the armed spawn
        send_cmd(CMD_INIT, 32'hFFFF_FFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF);
        send_cmd(CMD_TICK, 32'd311, 16'd1000, 15'd3, 15'd4);
        settle();
    endtask

    // saturation, zero life, zero spread, expiry, timer wrap
    task automatic test_corner_cases();
        write_all(48'h8000_7FFF_8000, 48'h7FFF_8000_7FFF, 32'h0000_00FF, 32'hFF00_FF00,
                  16'd0, 16'hFFFF, 16'd2000, 16'd2000);
        send_cmd(CMD_INIT, 32'd0, 16'd0, 15'd0, 15'd0);
        send_cmd(CMD_TICK, 32'hFFFF_FFF0, 16'hFFFF, 15'd1999, 15'd0);
        send_cmd(CMD_TICK, 32'hFFFF_FFF1, 16'hFFFF, 15'd0, 15'd1999);
        send_cmd(CMD_TICK, 32'h0000_0002, 16'hFFFF, 15'h7FFF, 15'h7FFF);
        send_cmd(CMD_TICK, 32'h0000_0003, 16'hFFFF, 15'd1, 15'd1);
        settle();
        write_reg(REG_SPREAD_X, 48'd0);
        write_reg(REG_SPREAD_Y, 48'd0);
        write_reg(REG_LIFE, 48'd1);
        send_cmd(CMD_TICK, 32'd10, 16'd300, 15'h7FFF, 15'h5555);
        send_cmd(CMD_TICK, 32'd11, 16'd300, 15'h2AAA, 15'h7FFF);
        send_cmd(CMD_TICK, 32'd40, 16'd300, 15'd9, 15'd9);
        settle();
    endtask

    task automatic test_random_moderate();
        write_all(48'({$urandom, $urandom}), {4'h0, 12'($urandom), 4'hF, 12'($urandom),
                  4'h0, 12'($urandom)}, $urandom, $urandom, 16'd1000,
                  16'($urandom_range(1, 300)), 16'($urandom_range(1, 4000)),
                  16'($urandom_range(1, 4000)));
        send_cmd(CMD_INIT, 32'd0, 16'd0, 15'd0, 15'd0);
        run_frames(55, 32'd1000, 24);
        settle();
    endtask

    task automatic test_random_extreme();
        write_all(48'({$urandom, $urandom}), 48'({$urandom, $urandom}), $urandom, $urandom,
                  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_cmd(CMD_INIT, 32'd0, 16'd0, 15'd0, 15'd0);
        run_frames(50, 32'hFFF0_0000, 1200);
        settle();
    endtask

    // long receiver stall while commands keep coming
    task automatic test_backpressure();
        write_reg(REG_LIFE, 48'd300);
        write_reg(REG_SPEED, 48'd3);
        send_cmd(CMD_INIT, 32'd0, 16'd0, 15'd0, 15'd0);
        run_frames(20, 32'd50, 6);
        hold_req = 1;
        run_frames(10, 32'd200, 6);
        settle();
    endtask

    task automatic test_random_steady();
        quiet = 1;
        write_reg(REG_LIFE, 48'd500);
        write_reg(REG_SPEED, 48'd40);
        send_cmd(CMD_INIT, 32'd0, 16'd0, 15'd0, 15'd0);
        run_frames(35, 32'd7777, 12);
        settle();
    endtask

    initial begin
        emit_pos = '0;
        base_dir = '0;
        start_col = 32'hFFFF_FFFF;
        end_col = '0;
        life_ms = 16'd1000;
        speed = '0;
        spread_x = 16'd1;
        spread_y = 16'd1;
        for (int i = 0; i < NUM_PARTICLES; i++) slot_alive[i] = 0;
        for (int c = 0; c < 4; c++) fade_rate[c] = 0;
        spawn_armed = 0;
        last_spawn = '0;
        n_errors = 0;
        n_items = 0;
        n_reports = 0;
        n_spawns = 0;
        quiet = 0;
        hold_req = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_EMIT_POS;
        i_cfg_data = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_spawn_motion();
        test_corner_cases();
        test_random_moderate();
        test_random_extreme();
        test_backpressure();
        test_random_steady();

        $display("%0d commands sent, %0d particle reports checked, %0d spawns predicted",
                 n_items, n_reports, n_spawns);
        $display("covered saturation, expiry, timer wrap, zero life and spread, long stall");
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
